/* sv/cpatc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the CPA/TCPA collision check.
// Depends on nothing; used by the top level, both checkers and the testbench.
package cpatc_pkg;

    // Default trig resolution: table entries per full turn
    localparam int unsigned TRIG_ENTRIES_DEF = 1024;

    // Sine polynomial coefficients, Q14
    localparam int unsigned POLY_A = 25736;
    localparam int unsigned POLY_B = 10512;
    localparam int unsigned POLY_C = 1160;

    // Angle spans
    localparam int unsigned LAT_SPAN     = 360000000;  // microdegrees per turn
    localparam int unsigned COURSE_SPAN  = 36000;      // 0.01 degrees per turn
    localparam int unsigned QUARTER_TURN = 16384;      // Q16 turn fraction

    // Stream widths
    localparam int unsigned IN_DATA_W  = 176;
    localparam int unsigned OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_CPA_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TCPA_LIMIT  = 2'd1;
    localparam logic [1:0] REG_MIN_REL_SPD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] CPA_LIMIT_RST   = 16'd2000;
    localparam logic [7:0]  TCPA_LIMIT_RST  = 8'd15;
    localparam logic [15:0] MIN_REL_SPD_RST = 16'd100;

    typedef enum logic [1:0] {
        VERDICT_STILL   = 2'd0,
        VERDICT_OUTSIDE = 2'd1,
        VERDICT_FAR     = 2'd2,
        VERDICT_RISK    = 2'd3
    } verdict_t;

endpackage

/* sv/collision_cpa_tcpa_check.sv */
`timescale 1ns / 1ps
// Top level of the CPA/TCPA collision check: one 18-stage pipeline.
// Depends on cpatc_pkg.
//
// Usage
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one own-ship/target pair
//   per request; master stream (m_tvalid/m_tready/m_tdata) returns one verdict
//   per request, in order. An APB port sets the CPA limit, the TCPA limit and
//   the stationary threshold; write them only while no request is in flight.
//   m_tvalid rises once the request has reached stage 18. Throughput: one
//   request per cycle while the receiver takes results, set by the fully
//   pipelined datapath (index division by reciprocal, five parallel sine
//   polynomials, 32x32 product stages and a split 128-bit compare).
//   Each stage advances when its successor is empty or advancing, so when the
//   receiver stalls the last result holds, bubbles ahead of it close up and
//   s_tready falls only once every stage is full. Nothing is dropped or
//   repeated.
//   Reset clears every valid bit and loads the registers with their defaults
//   (CPA limit 2000, TCPA limit 15, stationary threshold 100).
//   Longitude is not wrapped at the antimeridian.
module collision_cpa_tcpa_check
#(
    parameter int unsigned TRIG_TABLE_ENTRIES = cpatc_pkg::TRIG_ENTRIES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // own_lat[27:0], own_lon[56:28], own_speed[70:57], own_course[86:71],
    // tgt_lat[114:87], tgt_lon[143:115], tgt_speed[157:144],
    // tgt_course[173:158], zero[175:174]
    input  logic [cpatc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // collision_risk[0], verdict[2:1], zero[7:3]
    output logic [cpatc_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import cpatc_pkg::*;

    localparam int unsigned NS = 18;
    localparam int unsigned IW = $clog2(TRIG_TABLE_ENTRIES);
    localparam int unsigned KW = IW + 1;

    // Reciprocals for the constant divisions: estimate, then one correction
    localparam int unsigned LAT_SH = 28;
    localparam int unsigned CRS_SH = 16;
    localparam int unsigned TRN_SH = IW;
    localparam logic [17:0] LAT_RCP = 18'(((64'(TRIG_TABLE_ENTRIES) << LAT_SH)
                                            / 64'(LAT_SPAN)) + 64'd1);
    localparam logic [17:0] CRS_RCP = 18'(((64'(TRIG_TABLE_ENTRIES) << CRS_SH)
                                            / 64'(COURSE_SPAN)) + 64'd1);
    localparam logic [17:0] TRN_RCP = 18'(((64'd65536 << TRN_SH)
                                            / 64'(TRIG_TABLE_ENTRIES)) + 64'd1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] cpa_limit_reg;
    logic [7:0]  tcpa_limit_reg;
    logic [15:0] min_rel_speed_sq_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpa_limit_reg        <= CPA_LIMIT_RST;
            tcpa_limit_reg       <= TCPA_LIMIT_RST;
            min_rel_speed_sq_reg <= MIN_REL_SPD_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_CPA_LIMIT:   cpa_limit_reg        <= pwdata[15:0];
                REG_TCPA_LIMIT:  tcpa_limit_reg       <= pwdata[7:0];
                REG_MIN_REL_SPD: min_rel_speed_sq_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CPA_LIMIT:   prdata = {16'd0, cpa_limit_reg};
            REG_TCPA_LIMIT:  prdata = {24'd0, tcpa_limit_reg};
            REG_MIN_REL_SPD: prdata = {16'd0, min_rel_speed_sq_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic [NS:1]   valid_reg;
    logic [NS+1:1] en;

    always_comb
    begin
        en[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = valid_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, absolute latitude, course wrap, position deltas
    // ------------------------------------------------------------------
    logic signed [27:0] in_olat, in_tlat;
    logic signed [28:0] in_olon, in_tlon;
    logic        [15:0] in_ocrs, in_tcrs;

    assign in_olat = s_tdata[27:0];
    assign in_olon = s_tdata[56:28];
    assign in_ocrs = s_tdata[86:71];
    assign in_tlat = s_tdata[114:87];
    assign in_tlon = s_tdata[143:115];
    assign in_tcrs = s_tdata[173:158];

    logic        [27:0] alat_reg [1:2];
    logic        [15:0] ocrs_reg [1:2];
    logic        [15:0] tcrs_reg [1:2];
    logic signed [30:0] dlon_reg [1:10];
    logic signed [28:0] dlat_reg [1:12];
    logic        [13:0] ospd_reg [1:10];
    logic        [13:0] tspd_reg [1:10];

    // Stage 2: quotient estimates
    logic [KW-1:0] lat_est_reg;
    logic [KW-1:0] ocrs_est_reg;
    logic [KW-1:0] tcrs_est_reg;
    logic [45:0]   lat_prod;
    logic [33:0]   ocrs_prod, tcrs_prod;

    assign lat_prod  = 46'(alat_reg[1]) * 46'(LAT_RCP);
    assign ocrs_prod = 34'(ocrs_reg[1]) * 34'(CRS_RCP);
    assign tcrs_prod = 34'(tcrs_reg[1]) * 34'(CRS_RCP);

    // Stage 3: corrected table indexes (0 latitude, 1 own course, 2 target)
    logic [IW-1:0] idx_reg [1:2][0:2];
    logic [KW-1:0] lat_k, ocrs_k, tcrs_k;

    always_comb
    begin
        lat_k  = lat_est_reg;
        ocrs_k = ocrs_est_reg;
        tcrs_k = tcrs_est_reg;
        if (48'(lat_est_reg) * 48'(LAT_SPAN) > 48'(alat_reg[2]) * 48'(TRIG_TABLE_ENTRIES))
        begin
            lat_k = lat_est_reg - KW'(1);
        end
        if (40'(ocrs_est_reg) * 40'(COURSE_SPAN)
            > 40'(ocrs_reg[2]) * 40'(TRIG_TABLE_ENTRIES))
        begin
            ocrs_k = ocrs_est_reg - KW'(1);
        end
        if (40'(tcrs_est_reg) * 40'(COURSE_SPAN)
            > 40'(tcrs_reg[2]) * 40'(TRIG_TABLE_ENTRIES))
        begin
            tcrs_k = tcrs_est_reg - KW'(1);
        end
    end

    // Stage 4: turn fraction estimates, stage 5: corrected turn fractions
    logic [16:0] turn_est_reg [0:2];
    logic [15:0] turn_reg [0:2];
    logic [16:0] turn_fix [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            turn_fix[i] = turn_est_reg[i];
            if (40'(turn_est_reg[i]) * 40'(TRIG_TABLE_ENTRIES) > (40'(idx_reg[2][i]) << 16))
            begin
                turn_fix[i] = turn_est_reg[i] - 17'd1;
            end
        end
    end

    // Stage 6..10: five sine lanes
    // lane 0 cos(lat), 1 sin(own), 2 cos(own), 3 sin(tgt), 4 cos(tgt)
    logic [15:0]        ang [0:4];
    logic [14:0]        x_reg   [6:9][0:4];
    logic [4:0]         neg_reg [6:9];
    logic [14:0]        x2_reg  [7:8][0:4];
    logic [13:0]        t1_reg  [0:4];
    logic [14:0]        t2_reg  [0:4];
    logic signed [16:0] sin_reg [0:4];

    assign ang[0] = turn_reg[0] + 16'(QUARTER_TURN);
    assign ang[1] = turn_reg[1];
    assign ang[2] = turn_reg[1] + 16'(QUARTER_TURN);
    assign ang[3] = turn_reg[2];
    assign ang[4] = turn_reg[2] + 16'(QUARTER_TURN);

    // Stage 11..14: plane position, velocities, cross products
    logic signed [47:0] prod_reg;
    logic signed [31:0] vel_reg [0:3];   // own x, own y, target x, target y
    logic signed [31:0] px_reg, dvx_reg, dvy_reg;
    logic signed [63:0] dvxx_reg, dvyy_reg, xdvx_reg, ydvy_reg, xdvy_reg, ydvx_reg;
    logic        [63:0] w_reg;
    logic signed [63:0] s_reg, cr_reg;
    logic signed [47:0] prod_neg;

    assign prod_neg = -prod_reg;

    // Stage 15..18: decision
    logic        still_reg, spos_reg;
    logic [67:0] absd9_reg;
    logic [63:0] absc_reg;
    logic [45:0] lim2_reg;
    logic [44:0] tw_lo_reg, tw_hi_reg;
    logic [63:0] absd, absc_abs, absc;
    logic [12:0] tl25;
    logic [22:0] lim;
    logic [63:0] w_reg_15;

    assign absd     = 64'(-s_reg);
    assign absc_abs = cr_reg[63] ? 64'(-cr_reg) : 64'(cr_reg);
    assign absc     = 64'(absc_abs * 64'd6);
    assign tl25     = 13'(13'(tcpa_limit_reg) * 13'd25);
    assign lim      = 23'(23'(cpa_limit_reg) * 23'd100);

    verdict_t    pre_reg [16:17];
    logic        pend_reg [16:17];
    logic [63:0] aa_ll_reg, aa_lh_reg, aa_hh_reg;
    logic [54:0] lw_reg [0:3];
    logic [76:0] tcpa_lhs;
    logic [81:0] tcpa_rhs;
    logic [127:0] sq_reg, lw_sum_reg;
    verdict_t    verdict_reg;
    verdict_t    verdict16;

    assign tcpa_lhs = (77'(tw_hi_reg) << 32) + 77'(tw_lo_reg);
    assign tcpa_rhs = 82'(absd9_reg) << 14;

    always_comb
    begin
        if (still_reg)
        begin
            verdict16 = VERDICT_STILL;
        end
        else if (spos_reg || (82'(tcpa_lhs) < tcpa_rhs))
        begin
            verdict16 = VERDICT_OUTSIDE;
        end
        else
        begin
            verdict16 = VERDICT_FAR;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // stage 1
        if (en[1])
        begin
            alat_reg[1] <= in_olat[27] ? 28'(-in_olat) : 28'(in_olat);
            ocrs_reg[1] <= (in_ocrs >= 16'(COURSE_SPAN)) ? in_ocrs - 16'(COURSE_SPAN) : in_ocrs;
            tcrs_reg[1] <= (in_tcrs >= 16'(COURSE_SPAN)) ? in_tcrs - 16'(COURSE_SPAN) : in_tcrs;
            dlon_reg[1] <= 31'(in_tlon) - 31'(in_olon);
            dlat_reg[1] <= 29'(in_tlat) - 29'(in_olat);
            ospd_reg[1] <= s_tdata[70:57];
            tspd_reg[1] <= s_tdata[157:144];
        end
        // carried operands
        if (en[2])
        begin
            alat_reg[2] <= alat_reg[1];
            ocrs_reg[2] <= ocrs_reg[1];
            tcrs_reg[2] <= tcrs_reg[1];
        end
        for (int k = 2; k <= 10; k++)
        begin
            if (en[k])
            begin
                dlon_reg[k] <= dlon_reg[k-1];
                ospd_reg[k] <= ospd_reg[k-1];
                tspd_reg[k] <= tspd_reg[k-1];
            end
        end
        for (int k = 2; k <= 12; k++)
        begin
            if (en[k])
            begin
                dlat_reg[k] <= dlat_reg[k-1];
            end
        end
        // stage 2
        if (en[2])
        begin
            lat_est_reg  <= KW'(lat_prod >> LAT_SH);
            ocrs_est_reg <= KW'(ocrs_prod >> CRS_SH);
            tcrs_est_reg <= KW'(tcrs_prod >> CRS_SH);
        end
        // stage 3
        if (en[3])
        begin
            idx_reg[1][0] <= IW'(lat_k);
            idx_reg[1][1] <= IW'(ocrs_k);
            idx_reg[1][2] <= IW'(tcrs_k);
        end
        // stage 4
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                turn_est_reg[i] <= 17'((36'(idx_reg[1][i]) * 36'(TRN_RCP)) >> TRN_SH);
                idx_reg[2][i]   <= idx_reg[1][i];
            end
        end
        // stage 5
        if (en[5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                turn_reg[i] <= turn_fix[i][15:0];
            end
        end
        // stage 6: fold into the first quarter
        if (en[6])
        begin
            for (int i = 0; i < 5; i++)
            begin
                x_reg[6][i]   <= ang[i][14] ? 15'(QUARTER_TURN) - {1'b0, ang[i][13:0]}
                                            : {1'b0, ang[i][13:0]};
                neg_reg[6][i] <= ang[i][15];
            end
        end
        for (int k = 7; k <= 9; k++)
        begin
            if (en[k])
            begin
                x_reg[k]   <= x_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        // stages 7..10: polynomial
        for (int i = 0; i < 5; i++)
        begin
            if (en[7])
            begin
                x2_reg[7][i] <= 15'((30'(x_reg[6][i]) * 30'(x_reg[6][i])) >> 14);
            end
            if (en[8])
            begin
                x2_reg[8][i] <= x2_reg[7][i];
                t1_reg[i]    <= 14'(POLY_B)
                                - 14'((26'(x2_reg[7][i]) * 26'(POLY_C)) >> 14);
            end
            if (en[9])
            begin
                t2_reg[i] <= 15'(POLY_A)
                             - 15'((30'(x2_reg[8][i]) * 30'(t1_reg[i])) >> 14);
            end
            if (en[10])
            begin
                sin_reg[i] <= neg_reg[9][i]
                    ? -17'((30'(x_reg[9][i]) * 30'(t2_reg[i])) >> 14)
                    :  17'((30'(x_reg[9][i]) * 30'(t2_reg[i])) >> 14);
            end
        end
        // stage 11: scale longitude, split speeds
        if (en[11])
        begin
            prod_reg   <= 48'(dlon_reg[10]) * 48'(sin_reg[0]);
            vel_reg[0] <= $signed({1'b0, ospd_reg[10]}) * sin_reg[1];
            vel_reg[1] <= $signed({1'b0, ospd_reg[10]}) * sin_reg[2];
            vel_reg[2] <= $signed({1'b0, tspd_reg[10]}) * sin_reg[3];
            vel_reg[3] <= $signed({1'b0, tspd_reg[10]}) * sin_reg[4];
        end
        // stage 12: truncate toward zero, relative velocity
        if (en[12])
        begin
            px_reg  <= prod_reg[47] ? -32'(prod_neg >>> 14) : 32'(prod_reg >>> 14);
            dvx_reg <= vel_reg[2] - vel_reg[0];
            dvy_reg <= vel_reg[3] - vel_reg[1];
        end
        // stage 13: products
        if (en[13])
        begin
            dvxx_reg <= 64'(dvx_reg) * 64'(dvx_reg);
            dvyy_reg <= 64'(dvy_reg) * 64'(dvy_reg);
            xdvx_reg <= 64'(px_reg) * 64'(dvx_reg);
            ydvy_reg <= 64'(dlat_reg[12]) * 64'(dvy_reg);
            xdvy_reg <= 64'(px_reg) * 64'(dvy_reg);
            ydvx_reg <= 64'(dlat_reg[12]) * 64'(dvx_reg);
        end
        // stage 14: speed squared, dot and cross
        if (en[14])
        begin
            w_reg  <= 64'(dvxx_reg) + 64'(dvyy_reg);
            s_reg  <= xdvx_reg + ydvy_reg;
            cr_reg <= xdvy_reg - ydvx_reg;
        end
        // stage 15: thresholds and first partial products
        if (en[15])
        begin
            still_reg <= (w_reg == 64'd0)
                         || (w_reg < (64'(min_rel_speed_sq_reg) << 28));
            spos_reg  <= !s_reg[63] && (s_reg != 64'sd0);
            absd9_reg <= 68'(absd) + (68'(absd) << 3);
            absc_reg  <= absc;
            lim2_reg  <= 46'(lim) * 46'(lim);
            tw_lo_reg <= 45'(tl25) * 45'(w_reg[31:0]);
            tw_hi_reg <= 45'(tl25) * 45'(w_reg[63:32]);
            w_reg_15  <= w_reg;
        end
        // stage 16: TCPA window, CPA partial products
        if (en[16])
        begin
            pre_reg[16]  <= verdict16;
            pend_reg[16] <= (verdict16 == VERDICT_FAR);
            aa_ll_reg    <= 64'(absc_reg[31:0]) * 64'(absc_reg[31:0]);
            aa_lh_reg    <= 64'(absc_reg[31:0]) * 64'(absc_reg[63:32]);
            aa_hh_reg    <= 64'(absc_reg[63:32]) * 64'(absc_reg[63:32]);
            lw_reg[0]    <= 55'(lim2_reg[22:0])  * 55'(w_reg_15[31:0]);
            lw_reg[1]    <= 55'(lim2_reg[22:0])  * 55'(w_reg_15[63:32]);
            lw_reg[2]    <= 55'(lim2_reg[45:23]) * 55'(w_reg_15[31:0]);
            lw_reg[3]    <= 55'(lim2_reg[45:23]) * 55'(w_reg_15[63:32]);
        end
        // stage 17: sum partial products
        if (en[17])
        begin
            pre_reg[17]  <= pre_reg[16];
            pend_reg[17] <= pend_reg[16];
            sq_reg       <= (128'(aa_hh_reg) << 64) + (128'(aa_lh_reg) << 33)
                            + 128'(aa_ll_reg);
            lw_sum_reg   <= 128'(lw_reg[0]) + (128'(lw_reg[1]) << 32)
                            + (128'(lw_reg[2]) << 23) + (128'(lw_reg[3]) << 55);
        end
        // stage 18: final verdict
        if (en[18])
        begin
            if (pend_reg[17])
            begin
                verdict_reg <= (sq_reg < lw_sum_reg) ? VERDICT_RISK : VERDICT_FAR;
            end
            else
            begin
                verdict_reg <= pre_reg[17];
            end
        end
    end

    assign m_tdata = {5'd0, verdict_reg, (verdict_reg == VERDICT_RISK)};

endmodule

/* sv/cpatc_check.sv */
`timescale 1ns / 1ps
// Port-level checker for the CPA/TCPA collision check, bound to the top level.
// Depends on cpatc_pkg and collision_cpa_tcpa_check.
module cpatc_check
(
    input logic                                clk,
    input logic                                rst_n,
    input logic [cpatc_pkg::IN_DATA_W-1:0]     s_tdata,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [cpatc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic                                pready
);
    import cpatc_pkg::*;

    // Risk flag agrees with the verdict code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == VERDICT_RISK)))
        else $error("risk flag disagrees with verdict");

    // An empty output stage never back-pressures the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Padding bits stay clear and the register port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready && (!m_tvalid || (m_tdata[7:3] == 5'd0)))
        else $error("padding set or register port waiting");

endmodule

bind collision_cpa_tcpa_check cpatc_check u_cpatc_check (.*);

/* tb/sv/cpatc_verdict_checker.sv */
`timescale 1ns / 1ps
// Checker for the CPA/TCPA collision check: watches both streams and the APB
// write port, predicts each verdict and compares. Depends on cpatc_pkg.
module cpatc_verdict_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [cpatc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [cpatc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output int                                  fail_count,
    output int                                  pending_count
);
    import cpatc_pkg::*;

    localparam longint unsigned N = TRIG_ENTRIES_DEF;

    logic [15:0] cpa_lim;
    logic [7:0]  tcpa_lim;
    logic [15:0] still_lim;
    verdict_t    verdict_queue[$];

    function automatic longint sine_q14(longint unsigned f);
        longint unsigned q, x, x2, t, s;
        f = f & 64'hFFFF;
        q = f >> 14;
        x = f & 64'h3FFF;
        if (q[0])
            x = QUARTER_TURN - x;
        x2 = (x * x) >> 14;
        t = POLY_B - ((x2 * POLY_C) >> 14);
        t = POLY_A - ((x2 * t) >> 14);
        s = (x * t) >> 14;
        return q[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint unsigned heading_turn(logic [15:0] c);
        longint unsigned k;
        k = ((longint'(c) % COURSE_SPAN) * N) / COURSE_SPAN;
        return (k * 65536) / N;
    endfunction

    function automatic verdict_t judge_encounter(logic [IN_DATA_W-1:0] d);
        longint olat, olon, tlat, tlon, ospd, tspd, coslat, prod, x, y;
        longint dvx, dvy, s, cr;
        longint unsigned alat, w, fo, ft, absc, lim;
        logic [127:0] lhs, rhs;
        olat = longint'($signed(d[27:0]));
        olon = longint'($signed(d[56:28]));
        ospd = longint'(d[70:57]);
        tlat = longint'($signed(d[114:87]));
        tlon = longint'($signed(d[143:115]));
        tspd = longint'(d[157:144]);
        alat = longint'(olat < 0 ? -olat : olat) % LAT_SPAN;
        coslat = sine_q14((((alat * N) / LAT_SPAN) * 65536) / N + QUARTER_TURN);
        prod = (tlon - olon) * coslat;
        x = prod >= 0 ? (prod >>> 14) : -((-prod) >>> 14);
        y = tlat - olat;
        fo = heading_turn(d[86:71]);
        ft = heading_turn(d[173:158]);
        dvx = tspd * sine_q14(ft) - ospd * sine_q14(fo);
        dvy = tspd * sine_q14(ft + QUARTER_TURN) - ospd * sine_q14(fo + QUARTER_TURN);
        w = dvx * dvx + dvy * dvy;
        s = x * dvx + y * dvy;
        cr = x * dvy - y * dvx;
        if (w == 0 || w < (longint'(still_lim) << 28))
            return VERDICT_STILL;
        if (s > 0)
            return VERDICT_OUTSIDE;
        lhs = 128'(tcpa_lim * 25) * 128'(w);
        rhs = 128'(longint'(-s)) * 128'd147456;
        if (lhs < rhs)
            return VERDICT_OUTSIDE;
        lim = longint'(cpa_lim) * 100;
        absc = longint'(cr < 0 ? -cr : cr) * 6;
        lhs = 128'(absc) * 128'(absc);
        rhs = 128'(lim * lim) * 128'(w);
        return (lhs < rhs) ? VERDICT_RISK : VERDICT_FAR;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpa_lim   <= CPA_LIMIT_RST;
            tcpa_lim  <= TCPA_LIMIT_RST;
            still_lim <= MIN_REL_SPD_RST;
        end
        else
        begin
            // register writes land before the next request can be judged
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    REG_CPA_LIMIT:   cpa_lim   <= pwdata[15:0];
                    REG_TCPA_LIMIT:  tcpa_lim  <= pwdata[7:0];
                    REG_MIN_REL_SPD: still_lim <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                verdict_queue.push_back(judge_encounter(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (verdict_queue.size() == 0)
                    report_mismatch("verdict with no request outstanding");
                else
                begin
                    verdict_t want;
                    want = verdict_queue.pop_front();
                    if (m_tdata[2:1] != want)
                        report_mismatch($sformatf("verdict %0d, want %0d",
                                                  m_tdata[2:1], want));
                    if (m_tdata[0] != (want == VERDICT_RISK))
                        report_mismatch($sformatf("risk flag %0d for verdict %0d",
                                                  m_tdata[0], want));
                end
            end
            pending_count = verdict_queue.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the CPA/TCPA collision check bench: clock, reset, APB writes, encounter
// stimulus and verdict. Depends on cpatc_pkg, the top level and cpatc_verdict_checker.
module testbench;
    import cpatc_pkg::*;

    localparam int LATENCY    = 18;
    localparam int STALL_MAX  = 10;
    localparam int DOG_LIMIT  = 4000;
    localparam int RANDOM_REQ = 950;

    // Index past the last register: the write must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [15:0] CPA_SET [4]   = '{16'd0, 16'd65535, 16'd2000, 16'd500};
    localparam logic [7:0]  TCPA_SET [4]  = '{8'd0, 8'd255, 8'd15, 8'd60};
    localparam logic [15:0] STILL_SET [4] = '{16'd0, 16'd65535, 16'd100, 16'd3};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    int                    fail_count, pending_count;
    int                    idle_cycles = 0;
    bit                    sink_quiet = 1'b0;

    always #2 clk = ~clk;

    collision_cpa_tcpa_check dut (.*);

    cpatc_verdict_checker checker_i (.*);

    // Watchdog: count cycles in which no request moves on either stream; stop at DOG_LIMIT.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: after a random gap, raise tready until a verdict shows, then may lower it.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = sink_quiet ? 0 : $urandom_range(0, STALL_MAX);
            repeat (gap) @(posedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (!sink_quiet && $urandom_range(0, 1))
                m_tready <= 1'b0;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one request and hold it until accepted; gap before it is random
    // unless the burst flag asks for back-to-back traffic.
    task automatic send_encounter(logic [IN_DATA_W-1:0] d, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_pair(
        int olat, int olon, int ospd, int ocrs,
        int tlat, int tlon, int tspd, int tcrs);
        return {2'b00, 16'(tcrs), 14'(tspd), 29'(tlon), 28'(tlat),
                16'(ocrs), 14'(ospd), 29'(olon), 28'(olat)};
    endfunction

    // Mostly realistic encounters: target within 0.2 degrees of own ship, on a random
    // course and speed, so every verdict turns up. About one in ten is pure noise.
    function automatic logic [IN_DATA_W-1:0] random_pair();
        int olat, olon, dlat, dlon;
        if ($urandom_range(0, 9) == 0)
            return {2'b00, 174'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom})};
        olat = $urandom_range(0, 170000000) - 85000000;
        olon = $urandom_range(0, 340000000) - 170000000;
        dlat = $urandom_range(0, 400000) - 200000;
        dlon = $urandom_range(0, 400000) - 200000;
        return pack_pair(olat, olon, $urandom_range(0, 3000), $urandom_range(0, 35999),
                         olat + dlat, olon + dlon, $urandom_range(0, 3000),
                         $urandom_range(0, 35999));
    endfunction

    // Drain: wait for all verdicts and let the pipeline empty before any write.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, head-on, parallel courses, wrapped course,
        // latitude past the pole, and equal ships with no relative motion.
        send_encounter(pack_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_encounter(pack_pair(0, 0, 1000, 0, 10000, 0, 1000, 18000), 1'b0);
        send_encounter(pack_pair(0, 0, 1000, 0, -10000, 0, 1000, 18000), 1'b0);
        send_encounter(pack_pair(0, 0, 1000, 9000, 3000, 5000, 1000, 9000), 1'b0);
        send_encounter(pack_pair(0, 0, 10230, 36000, 2000, 100, 10230, 65535), 1'b0);
        send_encounter(pack_pair(-90000000, -180000000, 10230, 35999,
                                 90000000, 180000000, 0, 0), 1'b0);
        send_encounter(pack_pair(28'h7FFFFFF, 29'h0FFFFFFF, 14'h3FFF, 16'hFFFF,
                                 28'h8000000, 29'h10000000, 14'h3FFF, 16'h0000), 1'b1);
        send_encounter(pack_pair(100000000, 10, 500, 4500, 100010000, 20, 700, 27000), 1'b1);
        send_encounter(pack_pair(-134000000, 0, 2000, 0, -134000000, 3000, 0, 0), 1'b1);
        send_encounter(pack_pair(45000000, 0, 200, 9000, 45000000, 2000, 200, 27000), 1'b0);
        send_encounter(pack_pair(0, 0, 10, 0, 50, 0, 11, 0), 1'b0);

        // Phases: each setting of the registers with a share of random traffic.
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            apb_write(REG_CPA_LIMIT, {16'($urandom), CPA_SET[phase]});
            apb_write(REG_TCPA_LIMIT, {24'($urandom), TCPA_SET[phase]});
            apb_write(REG_MIN_REL_SPD, {16'($urandom), STILL_SET[phase]});
            apb_write(REG_UNUSED, $urandom);
            sink_quiet = (phase == 2);
            for (int i = 0; i < RANDOM_REQ / 4; i++)
                send_encounter(random_pair(), phase == 2 || $urandom_range(0, 3) == 0);
        end

        drain();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
sv/cpatc_pkg.sv
sv/collision_cpa_tcpa_check.sv
sv/cpatc_check.sv
tb/sv/cpatc_verdict_checker.sv
tb/sv/testbench.sv
